// ===== rtl/permutation_inversion_enumerator_assert.svh =====
// Assertion macros shared by the checker of the permutation inversion enumerator.
`ifndef PERMUTATION_INVERSION_ENUMERATOR_ASSERT_SVH
`define PERMUTATION_INVERSION_ENUMERATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PIE_ASSERT_SAME(lbl, clk_s, rstn_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
		else $error("permutation_inversion_enumerator: check failed");

// The consequent must hold in the cycle after the antecedent.
`define PIE_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
		else $error("permutation_inversion_enumerator: check failed");

`endif

// ===== rtl/pie_pkg.sv =====
// Package of types, constants and functions for the permutation inversion enumerator.
`default_nettype none

package pie_pkg;

	localparam int MAX_ELEMS = 10;
	localparam int ELEM_W    = 4;
	localparam int SIZE_W    = 4;
	localparam int ROW_W     = 4;
	localparam int KEY_W     = 30;
	localparam int INV_W     = 6;
	localparam int WEIGHT_W  = 27;
	localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(4);

	typedef logic [ELEM_W-1:0] elem_t;
	typedef logic [SIZE_W-1:0] size_t;

	typedef enum logic {
		OP_ADVANCE,
		OP_RESTART
	} op_t;

	typedef struct packed {
		logic valid;
		op_t  op;
	} q_head_t;

	function automatic size_t eff_size(input size_t raw);
		size_t n;
		n = raw;
		if (raw < SIZE_W'(2)) begin
			n = SIZE_W'(2);
		end else if (raw > SIZE_W'(MAX_ELEMS)) begin
			n = SIZE_W'(MAX_ELEMS);
		end
		return n;
	endfunction

	function automatic logic [WEIGHT_W-1:0] dec_weight(input logic [ROW_W-1:0] idx);
		logic [WEIGHT_W-1:0] w;
		case (idx)
			4'd0: w = WEIGHT_W'(1);
			4'd1: w = WEIGHT_W'(10);
			4'd2: w = WEIGHT_W'(100);
			4'd3: w = WEIGHT_W'(1000);
			4'd4: w = WEIGHT_W'(10000);
			4'd5: w = WEIGHT_W'(100000);
			4'd6: w = WEIGHT_W'(1000000);
			4'd7: w = WEIGHT_W'(10000000);
			4'd8: w = WEIGHT_W'(100000000);
			default: w = '0;
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/pie_req_if.sv =====
// Request channel interface: valid, ready and the restart flag.
`default_nettype none

interface pie_req_if;
	logic valid;
	logic ready;
	logic restart;

	modport source(output valid, output restart, input ready);
	modport sink(input valid, input restart, output ready);
endinterface

`default_nettype wire

// ===== rtl/pie_rsp_if.sv =====
// Result channel interface: valid, ready, key, inversion count and last flag.
`default_nettype none

interface pie_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [pie_pkg::KEY_W-1:0]   perm_key;
	logic [pie_pkg::INV_W-1:0]   inversions;
	logic                        last;

	modport source(output valid, output perm_key, output inversions, output last,
		input ready);
	modport sink(input valid, input perm_key, input inversions, input last,
		output ready);
endinterface

`default_nettype wire

// ===== rtl/pie_front.sv =====
// Front end: accepts request words, classifies them and queues them for the back end.
`default_nettype none

module pie_front (
	input  wire logic        clk,
	input  wire logic        arst_n,
	pie_req_if.sink          req,
	input  wire logic        pop,
	output pie_pkg::q_head_t head
);

	pie_pkg::op_t op_q [2];
	logic         wr_ptr_q;
	logic         rd_ptr_q;
	logic [1:0]   count_q;
	logic         push;
	logic         do_pop;
	pie_pkg::op_t op_in;

	assign req.ready  = (count_q != 2'd2);
	assign push       = req.valid && req.ready;
	assign do_pop     = pop && (count_q != 2'd0);
	assign op_in      = req.restart ? pie_pkg::OP_RESTART : pie_pkg::OP_ADVANCE;
	assign head.valid = (count_q != 2'd0);
	assign head.op    = op_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
			op_q[0]  <= pie_pkg::OP_ADVANCE;
			op_q[1]  <= pie_pkg::OP_ADVANCE;
		end else begin
			if (push) begin
				op_q[wr_ptr_q] <= op_in;
				wr_ptr_q       <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 2'd1;
			end else if (!push && do_pop) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/pie_back.sv =====
// Back end: steps Heap's algorithm, counts inversions row by row and builds the key.
`default_nettype none

module pie_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire pie_pkg::size_t   n_eff,
	input  wire pie_pkg::q_head_t head,
	output logic                  pop,
	pie_rsp_if.source             rsp
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WALK,
		ST_SWAP_RD,
		ST_SWAP_WR,
		ST_ROWS,
		ST_EMIT
	} state_t;

	state_t                                   state_q;
	pie_pkg::elem_t                           perm_q [pie_pkg::MAX_ELEMS];
	pie_pkg::elem_t                           cnt_q  [pie_pkg::MAX_ELEMS];
	pie_pkg::elem_t                           sh_q   [pie_pkg::MAX_ELEMS];
	pie_pkg::size_t                           level_q;
	pie_pkg::elem_t                           p_q;
	pie_pkg::elem_t                           q_q;
	pie_pkg::elem_t                           tmp_q;
	logic [pie_pkg::ROW_W-1:0]                row_q;
	logic [pie_pkg::INV_W-1:0]                inv_q;
	logic [pie_pkg::KEY_W-1:0]                key_q;
	logic                                     rsp_valid_q;
	logic [pie_pkg::KEY_W-1:0]                rsp_key_q;
	logic [pie_pkg::INV_W-1:0]                rsp_inv_q;
	logic                                     rsp_last_q;

	pie_pkg::elem_t                           lvl_cnt;
	pie_pkg::elem_t                           rd_idx;
	pie_pkg::elem_t                           rd_elem;
	pie_pkg::size_t                           lim;
	logic [pie_pkg::MAX_ELEMS-1:0]            gt;
	logic [pie_pkg::MAX_ELEMS-1:0]            exh;
	logic [pie_pkg::ROW_W-1:0]                row_cnt;
	logic [pie_pkg::ELEM_W+pie_pkg::WEIGHT_W-1:0] prod;
	logic                                     last_flag;
	logic                                     slot_free;
	logic                                     emit;

	assign rsp.valid      = rsp_valid_q;
	assign rsp.perm_key   = rsp_key_q;
	assign rsp.inversions = rsp_inv_q;
	assign rsp.last       = rsp_last_q;

	assign pop       = (state_q == ST_IDLE) && head.valid;
	assign slot_free = !rsp_valid_q || rsp.ready;
	assign emit      = (state_q == ST_EMIT) && slot_free;
	assign lvl_cnt   = (level_q < pie_pkg::SIZE_W'(pie_pkg::MAX_ELEMS)) ? cnt_q[level_q] : '0;
	assign rd_idx    = (state_q == ST_SWAP_RD) ? p_q : q_q;
	assign rd_elem   = perm_q[rd_idx];
	assign lim       = n_eff - row_q;
	assign prod      = sh_q[0] * pie_pkg::dec_weight(row_q);
	assign row_cnt   = pie_pkg::ROW_W'($countones(gt));
	assign last_flag = &exh;

	always_comb begin
		gt     = '0;
		exh    = '1;
		for (int j = 1; j < pie_pkg::MAX_ELEMS; j++) begin
			gt[j]  = (pie_pkg::SIZE_W'(j) < lim) && (sh_q[0] > sh_q[j]);
			exh[j] = (pie_pkg::SIZE_W'(j) >= n_eff) || (cnt_q[j] >= pie_pkg::ELEM_W'(j));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			level_q     <= pie_pkg::SIZE_W'(1);
			p_q         <= '0;
			q_q         <= '0;
			tmp_q       <= '0;
			row_q       <= '0;
			inv_q       <= '0;
			key_q       <= '0;
			rsp_valid_q <= 1'b0;
			rsp_key_q   <= '0;
			rsp_inv_q   <= '0;
			rsp_last_q  <= 1'b0;
			for (int k = 0; k < pie_pkg::MAX_ELEMS; k++) begin
				perm_q[k] <= pie_pkg::ELEM_W'(k);
				cnt_q[k]  <= '0;
				sh_q[k]   <= '0;
			end
		end else begin
			if (emit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (head.valid) begin
						if (head.op == pie_pkg::OP_RESTART) begin
							level_q <= pie_pkg::SIZE_W'(1);
							for (int k = 0; k < pie_pkg::MAX_ELEMS; k++) begin
								perm_q[k] <= pie_pkg::ELEM_W'(k);
								cnt_q[k]  <= '0;
							end
						end else begin
							state_q <= ST_WALK;
						end
					end
				end
				ST_WALK: begin
					if (level_q >= n_eff) begin
						state_q <= ST_IDLE;
					end else if (lvl_cnt >= level_q) begin
						cnt_q[level_q] <= '0;
						level_q        <= level_q + pie_pkg::SIZE_W'(1);
					end else begin
						if (!level_q[0]) begin
							p_q <= '0;
							q_q <= level_q;
						end else begin
							p_q <= level_q;
							q_q <= (lvl_cnt >= pie_pkg::ELEM_W'(pie_pkg::MAX_ELEMS)) ? '0 : lvl_cnt;
						end
						state_q <= ST_SWAP_RD;
					end
				end
				ST_SWAP_RD: begin
					tmp_q   <= rd_elem;
					state_q <= ST_SWAP_WR;
				end
				ST_SWAP_WR: begin
					perm_q[p_q]    <= rd_elem;
					perm_q[q_q]    <= tmp_q;
					cnt_q[level_q] <= lvl_cnt + pie_pkg::ELEM_W'(1);
					level_q        <= pie_pkg::SIZE_W'(1);
					for (int k = 0; k < pie_pkg::MAX_ELEMS; k++) begin
						if (pie_pkg::ELEM_W'(k) == q_q) begin
							sh_q[k] <= tmp_q;
						end else if (pie_pkg::ELEM_W'(k) == p_q) begin
							sh_q[k] <= rd_elem;
						end else begin
							sh_q[k] <= perm_q[k];
						end
					end
					row_q   <= '0;
					inv_q   <= '0;
					key_q   <= '0;
					state_q <= ST_ROWS;
				end
				ST_ROWS: begin
					inv_q <= inv_q + pie_pkg::INV_W'(row_cnt);
					key_q <= key_q + prod[pie_pkg::KEY_W-1:0];
					for (int k = 0; k < pie_pkg::MAX_ELEMS - 1; k++) begin
						sh_q[k] <= sh_q[k+1];
					end
					row_q <= row_q + pie_pkg::ROW_W'(1);
					if (row_q == n_eff - pie_pkg::SIZE_W'(2)) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (slot_free) begin
						rsp_key_q   <= key_q;
						rsp_inv_q   <= inv_q;
						rsp_last_q  <= last_flag;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== rtl/permutation_inversion_enumerator.sv =====
// Top level of the permutation inversion enumerator.
//
// Request words on req carry one flag: restart high returns the permutation of
// perm_size elements to the identity and produces no result word; restart low
// advances to the next permutation in Heap's order. Each advance produces one word
// on rsp with the decimal key, the inversion count and a last flag, except once the
// enumeration is exhausted, when an advance produces nothing until a restart.
// perm_size is written through perm_size_we and perm_size_wdata; the user must
// write it only while the block is idle, as the block itself does not enforce it;
// values outside 2 to 10 act as the nearest bound. The back end takes one request
// word at a time and pops the next only once it has returned to idle. The sequencer
// walks one level and counts one row of inversions per cycle; a two-word queue in
// front keeps req ready until both of its entries are full. A stalled result word
// holds on rsp and the back end waits only when its next result finds the output
// register still full. Reset restores perm_size to 4, the identity permutation,
// zero counters and an empty queue and output register.
`default_nettype none

module permutation_inversion_enumerator (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        perm_size_we,
	input  wire logic [pie_pkg::SIZE_W-1:0]  perm_size_wdata,
	pie_req_if.sink                          req,
	pie_rsp_if.source                        rsp
);

	pie_pkg::size_t   perm_size_q;
	pie_pkg::size_t   n_eff;
	pie_pkg::q_head_t head;
	logic             pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			perm_size_q <= pie_pkg::SIZE_RESET;
		end else if (perm_size_we) begin
			perm_size_q <= perm_size_wdata;
		end
	end

	assign n_eff = pie_pkg::eff_size(perm_size_q);

	pie_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.pop    (pop),
		.head   (head)
	);

	pie_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.n_eff  (n_eff),
		.head   (head),
		.pop    (pop),
		.rsp    (rsp)
	);

endmodule

`default_nettype wire

// ===== rtl/pie_checker.sv =====
// Port-level checker for the permutation inversion enumerator and its bind.
`default_nettype none
`include "permutation_inversion_enumerator_assert.svh"

module pie_checker (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       req_valid,
	input wire logic                       req_ready,
	input wire logic                       rsp_valid,
	input wire logic                       rsp_ready,
	input wire logic [pie_pkg::KEY_W-1:0]  rsp_perm_key,
	input wire logic [pie_pkg::INV_W-1:0]  rsp_inversions,
	input wire logic                       rsp_last
);

	// A stalled result word keeps all of its fields.
	`PIE_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_perm_key) && $stable(rsp_inversions) && $stable(rsp_last))

	// Handshake signals are never unknown once reset is released.
	`PIE_ASSERT_SAME(a_hs_known, clk, arst_n, 1'b1, !$isunknown({req_valid, req_ready, rsp_valid, rsp_ready}))

	// Ten distinct digits bound both the key and the inversion count.
	`PIE_ASSERT_SAME(a_rsp_range, clk, arst_n, rsp_valid, rsp_inversions <= 6'd45 && rsp_perm_key < 30'd1000000000)

endmodule

bind permutation_inversion_enumerator pie_checker u_pie_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.req_valid      (req.valid),
	.req_ready      (req.ready),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.rsp_perm_key   (rsp.perm_key),
	.rsp_inversions (rsp.inversions),
	.rsp_last       (rsp.last)
);

`default_nettype wire
